>>> rtl/core/silr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// silr_pkg
// Shared types and constants of the slope-intercept line rasterizer.
// ----------------------------------------------------------------------------
package silr_pkg;

	localparam int COORD_W         = 6;
	localparam int PIX_W           = 8;
	localparam int CANVAS_SIZE_DEF = 64;
	localparam int SLOPE_SCALE     = 50;

	localparam int SLOPE_W   = 13;
	localparam int VAL_W     = 14;
	localparam int DIFF_W    = 15;
	localparam int MUL_B_W   = 8;
	localparam int PROD_W    = DIFF_W + MUL_B_W;
	localparam int DIV_NUM_W = 18;
	localparam int DIV_DEN_W = 12;
	localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

	typedef enum logic [1:0] {
		OP_SLOPE,
		OP_ICPT,
		OP_STEP,
		OP_START
	} div_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLASS,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_EMIT
	} ctrl_state_t;

	typedef struct packed {
		logic    load;
		logic    div_start;
		div_op_t op;
		logic    walk_init;
		logic    emit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic vertical;
		logic shallow;
		logic empty;
		logic div_done;
		logic emit_done;
	} ctrl_status_t;

endpackage

>>> rtl/core/silr_seg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// silr_seg_if
// Segment channel: two endpoints per transaction.
// ----------------------------------------------------------------------------
interface silr_seg_if;
	import silr_pkg::*;

	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] start_x;
	logic [COORD_W-1:0] start_y;
	logic [COORD_W-1:0] end_x;
	logic [COORD_W-1:0] end_y;

	modport source (output valid, start_x, start_y, end_x, end_y, input ready);
	modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

>>> rtl/core/silr_pix_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// silr_pix_if
// Pixel channel: one pixel per transaction, flagged on the last of a segment.
// ----------------------------------------------------------------------------
interface silr_pix_if;
	import silr_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_x;
	logic [PIX_W-1:0] pixel_y;
	logic             last_pixel;

	modport source (output valid, pixel_x, pixel_y, last_pixel, input ready);
	modport sink   (input valid, pixel_x, pixel_y, last_pixel, output ready);
endinterface

>>> rtl/core/silr_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// silr_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module silr_divider (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [silr_pkg::DIV_NUM_W-1:0]  num,
	input  logic [silr_pkg::DIV_DEN_W-1:0]  den,
	output logic [silr_pkg::DIV_NUM_W-1:0]  quo,
	output logic [silr_pkg::DIV_DEN_W-1:0]  rem,
	output logic                            done
);
	import silr_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;

	logic [DIV_DEN_W:0]   shifted;
	logic                 ge;
	logic [DIV_DEN_W:0]   diff;

	assign shifted = {rem_q, quo_q[DIV_NUM_W-1]};
	assign ge      = shifted >= {1'b0, den_q};
	assign diff    = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_NUM_W-2:0], ge};
			rem_q <= ge ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
		end
	end

	assign quo  = quo_q;
	assign rem  = rem_q;
	assign done = done_q;
endmodule

>>> rtl/core/silr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// silr_datapath
// Endpoint registers, slope/intercept setup through the shared divider,
// incremental quotient walk and the pixel output register.
// ----------------------------------------------------------------------------
module silr_datapath #(
	parameter int CANVAS_SIZE = silr_pkg::CANVAS_SIZE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  silr_pkg::ctrl_cmd_t           cmd,
	output silr_pkg::ctrl_status_t        status,
	input  logic [silr_pkg::COORD_W-1:0]  start_x,
	input  logic [silr_pkg::COORD_W-1:0]  start_y,
	input  logic [silr_pkg::COORD_W-1:0]  end_x,
	input  logic [silr_pkg::COORD_W-1:0]  end_y,
	silr_pix_if.source                    pix
);
	import silr_pkg::*;

	localparam logic [COORD_W-1:0]      COORD_MAX = COORD_W'(CANVAS_SIZE - 1);
	localparam logic signed [VAL_W-1:0] SCALE_V   = VAL_W'(SLOPE_SCALE);

	function automatic logic [COORD_W-1:0] sat(input logic [COORD_W-1:0] v);
		return (v > COORD_MAX) ? COORD_MAX : v;
	endfunction

	// endpoints after swap
	logic [COORD_W-1:0] x0_q, y0_q, x1_q, y1_q;
	logic [COORD_W-1:0] ax, ay, bx, by;

	logic [COORD_W-1:0]        dx, ady, lo, hi, stop, pos_q;
	logic signed [COORD_W:0]   dy;
	logic                      vertical, shallow, empty;

	logic signed [SLOPE_W-1:0] slope_q;
	logic [DIV_DEN_W-1:0]      slope_abs;
	logic                      slope_neg;
	logic signed [VAL_W-1:0]   ic_q, step_q, q_q, r_q;
	logic [5:0]                step_r_q;

	// multiplier and divider operands
	logic signed [DIFF_W-1:0]  mul_a, lo_diff;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  prod, prod_abs;
	logic [DIV_NUM_W-1:0]      div_num, div_quo;
	logic [DIV_DEN_W-1:0]      div_den, div_rem, den_q;
	logic                      div_neg, div_done, neg_q;
	div_op_t                   op_q;

	logic signed [VAL_W-1:0]   div_mag, trunc_v, floor_q, floor_r;
	logic                      adjust;

	logic signed [VAL_W-1:0]   q_next, r_next, r_sum, q_sum, tq;
	logic signed [VAL_W-1:0]   den_s;
	logic                      last;

	logic                      out_valid_q, out_last_q, slot_free, fire;
	logic [PIX_W-1:0]          out_x_q, out_y_q, pix_x, pix_y;

	assign ax = sat(start_x);
	assign ay = sat(start_y);
	assign bx = sat(end_x);
	assign by = sat(end_y);

	assign dx        = x1_q - x0_q;
	assign dy        = $signed({1'b0, y1_q}) - $signed({1'b0, y0_q});
	assign ady       = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
	assign lo        = (y0_q < y1_q) ? y0_q : y1_q;
	assign hi        = (y0_q < y1_q) ? y1_q : y0_q;
	assign vertical  = (dx == '0);
	assign shallow   = !vertical && (dx > ady);
	assign empty     = vertical ? (lo == hi) : (shallow && dx <= COORD_W'(1));
	assign stop      = shallow ? x1_q : hi;
	assign last      = (pos_q == stop - 1'b1);

	assign slope_neg = slope_q[SLOPE_W-1];
	assign slope_abs = slope_neg ? DIV_DEN_W'(-slope_q) : DIV_DEN_W'(slope_q);
	assign lo_diff   = $signed({{(DIFF_W-COORD_W){1'b0}}, lo})
	                   - $signed({ic_q[VAL_W-1], ic_q});

	always_comb begin
		mul_a   = '0;
		mul_b   = '0;
		div_den = DIV_DEN_W'(SLOPE_SCALE);
		unique case (cmd.op)
			OP_SLOPE: begin
				mul_a   = DIFF_W'(dy);
				mul_b   = MUL_B_W'(SLOPE_SCALE);
				div_den = DIV_DEN_W'(dx);
			end
			OP_ICPT: begin
				mul_a = DIFF_W'(slope_q);
				mul_b = $signed({2'b00, x0_q});
			end
			OP_STEP: begin
				mul_a = DIFF_W'(slope_q);
				mul_b = MUL_B_W'(1);
			end
			OP_START: begin
				if (shallow) begin
					mul_a = DIFF_W'(slope_q);
					mul_b = $signed({1'b0, 7'(x0_q) + 7'd1});
				end else begin
					mul_a   = lo_diff;
					mul_b   = MUL_B_W'(SLOPE_SCALE);
					div_den = slope_abs;
				end
			end
			default: ;
		endcase
	end

	assign prod     = mul_a * mul_b;
	assign prod_abs = prod[PROD_W-1] ? -prod : prod;
	assign div_num  = prod_abs[DIV_NUM_W-1:0];
	assign div_neg  = prod[PROD_W-1] ^ ((cmd.op == OP_START) && !shallow && slope_neg);

	silr_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.quo    (div_quo),
		.rem    (div_rem),
		.done   (div_done)
	);

	// signed result: truncated quotient and floor quotient/remainder
	assign div_mag = $signed(VAL_W'(div_quo));
	assign trunc_v = neg_q ? -div_mag : div_mag;
	assign adjust  = neg_q && (div_rem != '0);
	assign floor_q = adjust ? trunc_v - 1'b1 : trunc_v;
	assign floor_r = adjust ? $signed(VAL_W'(den_q - div_rem)) : $signed(VAL_W'(div_rem));

	// one walk step
	assign den_s = $signed(VAL_W'(slope_abs));
	always_comb begin
		q_next = q_q;
		r_next = r_q;
		r_sum  = '0;
		q_sum  = '0;
		if (shallow) begin
			r_sum = r_q + $signed(VAL_W'(step_r_q));
			q_sum = q_q + step_q;
			if (r_sum >= SCALE_V) begin
				r_next = r_sum - SCALE_V;
				q_next = q_sum + 1'b1;
			end else begin
				r_next = r_sum;
				q_next = q_sum;
			end
		end else if (!slope_neg) begin
			r_sum = r_q + SCALE_V;
			if (r_sum >= den_s) begin
				r_next = r_sum - den_s;
				q_next = q_q + 1'b1;
			end else begin
				r_next = r_sum;
			end
		end else begin
			r_sum = r_q - SCALE_V;
			if (r_sum < 0) begin
				r_next = r_sum + den_s;
				q_next = q_q - 1'b1;
			end else begin
				r_next = r_sum;
			end
		end
	end

	assign tq = q_q + ((q_q < 0 && r_q != '0) ? VAL_W'(1) : VAL_W'(0));

	always_comb begin
		if (vertical) begin
			pix_x = PIX_W'(x0_q);
			pix_y = PIX_W'(pos_q);
		end else if (shallow) begin
			pix_x = PIX_W'(pos_q);
			pix_y = PIX_W'(tq + ic_q);
		end else begin
			pix_x = PIX_W'(tq);
			pix_y = PIX_W'(pos_q);
		end
	end

	assign slot_free = !out_valid_q || pix.ready;
	assign fire      = cmd.emit && slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (pix.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			if (ax > bx) begin
				x0_q <= bx;
				y0_q <= by;
				x1_q <= ax;
				y1_q <= ay;
			end else begin
				x0_q <= ax;
				y0_q <= ay;
				x1_q <= bx;
				y1_q <= by;
			end
		end
		if (cmd.div_start) begin
			op_q  <= cmd.op;
			neg_q <= div_neg;
			den_q <= div_den;
		end
		if (div_done) begin
			unique case (op_q)
				OP_SLOPE: slope_q <= SLOPE_W'(trunc_v);
				OP_ICPT:  ic_q    <= $signed(VAL_W'(y0_q)) - trunc_v;
				OP_STEP: begin
					step_q   <= floor_q;
					step_r_q <= 6'(floor_r);
				end
				OP_START: begin
					q_q <= floor_q;
					r_q <= floor_r;
				end
				default: ;
			endcase
		end
		if (cmd.walk_init) begin
			pos_q <= shallow ? x0_q + 1'b1 : lo;
		end else if (fire) begin
			pos_q <= pos_q + 1'b1;
			q_q   <= q_next;
			r_q   <= r_next;
		end
		if (fire) begin
			out_x_q    <= pix_x;
			out_y_q    <= pix_y;
			out_last_q <= last;
		end
	end

	assign pix.valid      = out_valid_q;
	assign pix.pixel_x    = out_x_q;
	assign pix.pixel_y    = out_y_q;
	assign pix.last_pixel = out_last_q;

	assign status.vertical  = vertical;
	assign status.shallow   = shallow;
	assign status.empty     = empty;
	assign status.div_done  = div_done;
	assign status.emit_done = fire && last;
endmodule

>>> rtl/core/silr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// silr_ctrl
// Sequencer: classify segment, run setup divisions, then walk the pixels.
// ----------------------------------------------------------------------------
module silr_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  silr_pkg::ctrl_status_t status,
	output silr_pkg::ctrl_cmd_t    cmd
);
	import silr_pkg::*;

	ctrl_state_t state_q, state_d;
	div_op_t     op_q, op_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_SLOPE;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
		end
	end

	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_CLASS;
			end
			ST_CLASS: begin
				if (status.empty) begin
					state_d = ST_IDLE;
				end else if (status.vertical) begin
					state_d = ST_EMIT;
				end else begin
					op_d    = OP_SLOPE;
					state_d = ST_DIV_GO;
				end
			end
			ST_DIV_GO: state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (status.div_done) begin
					unique case (op_q)
						OP_SLOPE: begin
							op_d    = OP_ICPT;
							state_d = ST_DIV_GO;
						end
						OP_ICPT: begin
							op_d    = status.shallow ? OP_STEP : OP_START;
							state_d = ST_DIV_GO;
						end
						OP_STEP: begin
							op_d    = OP_START;
							state_d = ST_DIV_GO;
						end
						OP_START: state_d = ST_EMIT;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_EMIT: begin
				if (status.emit_done) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready      = (state_q == ST_IDLE);
		cmd.load      = (state_q == ST_IDLE) && in_valid;
		cmd.div_start = (state_q == ST_DIV_GO);
		cmd.op        = op_q;
		cmd.walk_init = ((state_q == ST_CLASS) && status.vertical && !status.empty)
		             || ((state_q == ST_DIV_WAIT) && status.div_done && op_q == OP_START);
		cmd.emit      = (state_q == ST_EMIT);
	end
endmodule

>>> rtl/core/slope_intercept_line_raster.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slope_intercept_line_raster
// Rasterizes one segment per transaction into a stream of pixels.
//
//   channel | dir | handshake     | payload
//   seg     | in  | valid / ready | start_x, start_y, end_x, end_y
//   pix     | out | valid / ready | pixel_x, pixel_y, last_pixel
//
// Setup classifies the segment, then runs divisions in the shared serial
// divider: 3 for a steep segment, 4 for a shallow one, none for a vertical
// one. Then one pixel per cycle, unless pix stalls, from an incremental
// quotient walk. One segment at a time; seg.ready is high only while idle.
// Reset clears the sequencer, divider control and pixel valid.
// A stalled pix channel holds the walk; the last pixel may still be waiting
// when the next segment is taken.
// ----------------------------------------------------------------------------
module slope_intercept_line_raster #(
	parameter int CANVAS_SIZE = silr_pkg::CANVAS_SIZE_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	silr_seg_if.sink   seg,
	silr_pix_if.source pix
);
	import silr_pkg::*;

	ctrl_cmd_t    cmd;
	ctrl_status_t status;
	logic         in_ready;

	assign seg.ready = in_ready;

	silr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (seg.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	silr_datapath #(
		.CANVAS_SIZE (CANVAS_SIZE)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.status  (status),
		.start_x (seg.start_x),
		.start_y (seg.start_y),
		.end_x   (seg.end_x),
		.end_y   (seg.end_y),
		.pix     (pix)
	);
endmodule
